// ===== hw/rtl/sfd_pkg.sv =====
// Shared constants and types for the stereo flanger delay block.
`default_nettype none
package sfd_pkg;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_STEP     = 2'd1,
    CFG_FEEDBACK = 2'd2,
    CFG_SPMS     = 2'd3
  } cfg_idx_t;

  localparam logic        RST_ENABLE   = 1'b0;
  localparam logic [31:0] RST_STEP     = 32'd48696;
  localparam logic [15:0] RST_FEEDBACK = 16'd9830;
  localparam logic [15:0] RST_SPMS     = 16'd11290;

  // power of two: the table angle is the index shifted up
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int MUL_W   = 33;
  localparam int WHOLE_W = 11;
  localparam int FRAC_W  = 8;
  localparam int LFO_W   = 17;

  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] SIN_C9  = 31'd172272;
  // Horner order after the x^9 term: c7, c5, c3, c1
  localparam logic [30:0] HORNER_C [4] = '{31'd5026996, 31'd85569306,
                                           31'd693598669, 31'd1686629713};

  localparam int GAIN_0707 = 23167;
  localparam int RND_HALF  = 16384;

endpackage
`default_nettype wire

// ===== hw/rtl/sfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stereo_flanger_delay_top.sv =====
// Stereo flanger with feedback: LFO sequencer, shared multiplier and delay line.
//
// One stereo pair per request. With the flanger enabled the request runs through the
// sequencer states and its result is registered in the result state; the next request
// is taken only once the sequencer is back in idle, so a new pair waits until the last
// one is done. One shared 33x33 multiplier computes the LFO table index, the sine
// polynomial, the delay length, the interpolation, the output gain and the feedback in
// turn; the table angle is the index shifted up, as the sine table depth is a power of
// two. The wrap state reduces the delay modulo DELAY_DEPTH when the line is shorter than
// the longest delay. Disabled, the request goes straight from idle to the result state,
// which registers the result when the output is free. A result waiting on out_ready holds
// the sequencer until it is taken. Both channels share one delay RAM; entries not written
// since reset read as zero through the fill state, so no clearing pass is needed.
`default_nettype none
module stereo_flanger_delay_top #(
  parameter int DELAY_DEPTH      = 2048,
  parameter int SAMPLE_BITS      = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out
);

  localparam int SB  = SAMPLE_BITS;
  localparam int SB1 = SB + 1;
  localparam int SBX = SB + 2;
  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int CW  = AW + 2;
  localparam int KW  = $clog2(sfd_pkg::SINE_TABLE_DEPTH);
  localparam int MW  = sfd_pkg::MUL_W;
  localparam int PW  = 2 * MW;
  localparam int WW  = sfd_pkg::WHOLE_W;
  localparam int FW  = sfd_pkg::FRAC_W;
  localparam int LW  = sfd_pkg::LFO_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);
  localparam logic signed [PW-1:0] HALF = PW'(sfd_pkg::RND_HALF);
  localparam logic signed [PW-1:0] SMAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;

  typedef enum logic [4:0] {
    ST_IDLE, ST_K_MUL, ST_K_GET, ST_X_PREP, ST_XX_MUL, ST_XX_GET,
    ST_H_MUL, ST_H_GET, ST_S_MUL, ST_S_GET, ST_D_MUL, ST_D_GET, ST_WRAP,
    ST_RD_A, ST_RD_B, ST_RD_C, ST_I_MUL, ST_I_GET, ST_O_MUL, ST_O_GET,
    ST_F_MUL, ST_F_GET, ST_WRITE, ST_DONE
  } state_t;

  function automatic logic signed [SB-1:0] sat_s(input logic signed [PW-1:0] v);
    if (v > SMAX) begin
      return SMAX[SB-1:0];
    end
    if (v < SMIN) begin
      return SMIN[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  // configuration
  logic               flanger_enable;
  logic [31:0]        lfo_phase_step;
  logic signed [15:0] feedback_gain;
  logic [15:0]        samples_per_ms;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      flanger_enable <= sfd_pkg::RST_ENABLE;
      lfo_phase_step <= sfd_pkg::RST_STEP;
      feedback_gain  <= sfd_pkg::RST_FEEDBACK;
      samples_per_ms <= sfd_pkg::RST_SPMS;
    end else if (cfg_wr) begin
      case (sfd_pkg::cfg_idx_t'(paddr[3:2]))
        sfd_pkg::CFG_ENABLE:   flanger_enable <= pwdata[0];
        sfd_pkg::CFG_STEP:     lfo_phase_step <= pwdata;
        sfd_pkg::CFG_FEEDBACK: feedback_gain  <= pwdata[15:0];
        sfd_pkg::CFG_SPMS:     samples_per_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sfd_pkg::cfg_idx_t'(paddr[3:2]))
      sfd_pkg::CFG_ENABLE:   prdata = {31'd0, flanger_enable};
      sfd_pkg::CFG_STEP:     prdata = lfo_phase_step;
      sfd_pkg::CFG_FEEDBACK: prdata = {{16{feedback_gain[15]}}, feedback_gain};
      sfd_pkg::CFG_SPMS:     prdata = {16'd0, samples_per_ms};
      default:               prdata = 32'd0;
    endcase
  end

  // sequencer and datapath registers
  state_t             state;
  logic [31:0]        phase;
  logic [AW-1:0]      wi;
  logic               full;
  logic               ch;
  logic [1:0]         hcnt;
  logic [31:0]        t;
  logic [30:0]        x;
  logic [30:0]        x2;
  logic [30:0]        p;
  logic [LW-1:0]      lfo;
  logic [WW-1:0]      whole;
  logic [FW-1:0]      frac;
  logic [AW-1:0]      rd;
  logic signed [SB-1:0] in_l, in_r, a_l, a_r, b_l, b_r, delayed;
  logic signed [SB-1:0] res_l, res_r, st_l, st_r;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  // RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [2*SB-1:0]      ram_rdata;

  // combinational helpers
  logic [31:0]          s_raw, lfo_sum;
  logic [30:0]          s_clamp;
  logic [18:0]          dly_mul;
  logic [CW-1:0]        whole_c, whole_sub, rd_dif, rd_fix;
  logic [AW-1:0]        rd1;
  logic                 vld_rd, vld_rd1;
  logic signed [SB-1:0] a_ch, b_ch, in_ch;
  logic signed [SB:0]   bdiff, insum;
  logic signed [SBX-1:0] itp;
  logic signed [PW-1:0] rnd, st_sum;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    s_raw     = prod[61:30];
    s_clamp   = (s_raw > 32'(sfd_pkg::Q30_ONE)) ? sfd_pkg::Q30_ONE : s_raw[30:0];
    lfo_sum   = t[31] ? (32'(sfd_pkg::Q30_ONE) - 32'(s_clamp))
                      : (32'(sfd_pkg::Q30_ONE) + 32'(s_clamp));
    dly_mul   = 19'd65536 + 19'({lfo, 2'b00}) + 19'({lfo, 1'b0});
    whole_c   = CW'(whole);
    whole_sub = whole_c - DEPTH_C;
    rd_dif    = CW'(wi) - whole_c;
    rd_fix    = rd_dif[CW-1] ? (rd_dif + DEPTH_C) : rd_dif;
    rd1       = (rd == LAST_IDX) ? '0 : (rd + 1'b1);
    vld_rd    = full || (rd < wi);
    vld_rd1   = full || (rd1 < wi);
    a_ch      = ch ? a_r : a_l;
    b_ch      = ch ? b_r : b_l;
    in_ch     = ch ? in_r : in_l;
    bdiff     = SB1'(b_ch) - SB1'(a_ch);
    insum     = SB1'(in_ch) + SB1'(delayed);
    itp       = SBX'(a_ch) + SBX'(prod >>> 8);
    rnd       = (prod + HALF) >>> 15;
    st_sum    = PW'(in_ch) + rnd;
    ram_raddr = (state == ST_RD_B) ? rd1 : rd;
    ram_we    = (state == ST_WRITE);
  end

  always_comb begin
    case (state)
      ST_K_MUL: begin
        mul_a = MW'(phase);
        mul_b = MW'(sfd_pkg::SINE_TABLE_DEPTH);
      end
      ST_XX_MUL: begin
        mul_a = MW'(x);
        mul_b = MW'(x);
      end
      ST_H_MUL: begin
        mul_a = MW'(x2);
        mul_b = MW'(p);
      end
      ST_S_MUL: begin
        mul_a = MW'(x);
        mul_b = MW'(p);
      end
      ST_D_MUL: begin
        mul_a = MW'(dly_mul);
        mul_b = MW'(samples_per_ms);
      end
      ST_I_MUL: begin
        mul_a = MW'(frac);
        mul_b = MW'(bdiff);
      end
      ST_O_MUL: begin
        mul_a = MW'(insum);
        mul_b = MW'(sfd_pkg::GAIN_0707);
      end
      ST_F_MUL: begin
        mul_a = MW'(delayed);
        mul_b = MW'(feedback_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  sfd_ram #(
    .WIDTH (2 * SB),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi),
    .wdata ({st_r, st_l}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      wi        <= '0;
      full      <= 1'b0;
      ch        <= 1'b0;
      hcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            in_l <= left_in;
            in_r <= right_in;
            if (flanger_enable) begin
              phase <= phase + lfo_phase_step;
              state <= ST_K_MUL;
            end else begin
              res_l <= left_in;
              res_r <= right_in;
              state <= ST_DONE;
            end
          end
        end
        ST_K_MUL: state <= ST_K_GET;
        ST_K_GET: begin
          t     <= {prod[32 +: KW], {(32-KW){1'b0}}};
          state <= ST_X_PREP;
        end
        ST_X_PREP: begin
          x     <= t[30] ? (sfd_pkg::Q30_ONE - {1'b0, t[29:0]}) : {1'b0, t[29:0]};
          state <= ST_XX_MUL;
        end
        ST_XX_MUL: state <= ST_XX_GET;
        ST_XX_GET: begin
          x2    <= prod[60:30];
          p     <= sfd_pkg::SIN_C9;
          hcnt  <= '0;
          state <= ST_H_MUL;
        end
        ST_H_MUL: state <= ST_H_GET;
        ST_H_GET: begin
          p    <= sfd_pkg::HORNER_C[hcnt] - prod[60:30];
          hcnt <= hcnt + 1'b1;
          state <= (hcnt == 2'd3) ? ST_S_MUL : ST_H_MUL;
        end
        ST_S_MUL: state <= ST_S_GET;
        ST_S_GET: begin
          lfo   <= lfo_sum[31:15];
          state <= ST_D_MUL;
        end
        ST_D_MUL: state <= ST_D_GET;
        ST_D_GET: begin
          whole <= prod[34:24];
          frac  <= prod[23:16];
          state <= ST_WRAP;
        end
        ST_WRAP: begin
          if (whole_c >= DEPTH_C) begin
            whole <= whole_sub[WW-1:0];
          end else begin
            rd    <= rd_fix[AW-1:0];
            state <= ST_RD_A;
          end
        end
        ST_RD_A: state <= ST_RD_B;
        ST_RD_B: begin
          a_l   <= vld_rd ? ram_rdata[SB-1:0] : '0;
          a_r   <= vld_rd ? ram_rdata[2*SB-1:SB] : '0;
          state <= ST_RD_C;
        end
        ST_RD_C: begin
          b_l   <= vld_rd1 ? ram_rdata[SB-1:0] : '0;
          b_r   <= vld_rd1 ? ram_rdata[2*SB-1:SB] : '0;
          ch    <= 1'b0;
          state <= ST_I_MUL;
        end
        ST_I_MUL: state <= ST_I_GET;
        ST_I_GET: begin
          delayed <= itp[SB-1:0];
          state   <= ST_O_MUL;
        end
        ST_O_MUL: state <= ST_O_GET;
        ST_O_GET: begin
          if (ch) begin
            res_r <= sat_s(rnd);
          end else begin
            res_l <= sat_s(rnd);
          end
          state <= ST_F_MUL;
        end
        ST_F_MUL: state <= ST_F_GET;
        ST_F_GET: begin
          if (ch) begin
            st_r  <= sat_s(st_sum);
            state <= ST_WRITE;
          end else begin
            st_l  <= sat_s(st_sum);
            ch    <= 1'b1;
            state <= ST_I_MUL;
          end
        end
        ST_WRITE: begin
          wi    <= (wi == LAST_IDX) ? '0 : (wi + 1'b1);
          full  <= full || (wi == LAST_IDX);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            left_out  <= res_l;
            right_out <= res_r;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !flanger_enable |=> state == ST_DONE)
    else $error("bypass request did not go straight to result");

  a_lfo_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_D_MUL |-> lfo <= 17'd65536)
    else $error("lfo value above unity");

  a_whole_wrapped: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_A |-> CW'(whole) < DEPTH_C)
    else $error("delay not reduced below line depth");

  a_wi_hold: assert property (@(posedge clk) disable iff (rst)
    !ram_we |=> $stable(wi))
    else $error("write index moved without a line write");
`endif

endmodule
`default_nettype wire
